/* rtl/rpd_pkg.sv */
package rpd_pkg;

	// Default depth of the command queue between front and back.
	localparam int CMD_DEPTH_DEF = 2;

	// Result kinds.
	localparam logic [1:0] KIND_HIT     = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// Error codes.
	localparam logic [2:0] ERR_TRUNC      = 3'd0;
	localparam logic [2:0] ERR_HDR_FLAG   = 3'd1;
	localparam logic [2:0] ERR_TRL_FLAG   = 3'd2;
	localparam logic [2:0] ERR_L1_LOW     = 3'd3;
	localparam logic [2:0] ERR_SEQ_FLAG1  = 3'd4;
	localparam logic [2:0] ERR_SEQ_FLAG2  = 3'd5;

	// Flag values in the packet words.
	localparam logic [2:0] HDR_FLAG  = 3'd6;
	localparam logic [2:0] TRL_FLAG  = 3'd7;
	localparam logic [3:0] SEQ_FLAG1 = 4'd4;
	localparam logic [3:0] SEQ_FLAG2 = 4'd0;

	// Parser phase of the front part.
	typedef enum logic [2:0] {
		PH_HEADER,
		PH_HITS,
		PH_TRAIL1,
		PH_TRAIL2,
		PH_DROP
	} phase_t;

	// Commands handed from front to back.
	typedef enum logic [2:0] {
		CMD_HEADER,
		CMD_HIT,
		CMD_TRAIL1,
		CMD_SUMMARY,
		CMD_ERROR
	} cmd_op_t;

	typedef struct packed {
		logic [63:0] beat;
		logic        block_last;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  chip_id;
		logic [2:0]  code_bits;
		logic [53:0] wide_value;
		logic [31:0] l1_count;
		logic [15:0] time_stamp;
		logic [7:0]  hits_in_packet;
		logic [23:0] l1_frame_number;
		logic [4:0]  board_id;
		logic [5:0]  channel_id;
		logic [17:0] last_count_word;
		logic [4:0]  seq_board_id;
	} result_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [2:0]  err;
		logic [63:0] beat;
	} cmd_t;

endpackage

/* rtl/rpd_front.sv */
module rpd_front
	import rpd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  item_t item,
	input  logic  push,
	input  logic  cmd_full,
	output logic  cmd_push,
	output cmd_t  cmd
);

	phase_t      phase_q, phase_d;
	logic [7:0]  hits_left_q, hits_left_d;
	logic [2:0]  l1_low_q, l1_low_d;
	logic        cmd_valid;
	logic        accept;
	logic [31:0] wa, wb;

	assign wa     = item.beat[31:0];
	assign wb     = item.beat[63:32];
	assign accept = push && !cmd_full;

	// Phase register and the few values the checks need.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hits_left_q <= '0;
			l1_low_q    <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			hits_left_q <= hits_left_d;
			l1_low_q    <= l1_low_d;
		end
	end

	// Classify the beat by phase, run its checks and pick the command.
	always_comb begin
		phase_d     = phase_q;
		hits_left_d = hits_left_q;
		l1_low_d    = l1_low_q;
		cmd_valid   = 1'b0;
		cmd.op      = CMD_HEADER;
		cmd.err     = ERR_TRUNC;
		cmd.beat    = item.beat;
		unique case (phase_q)
			PH_HEADER: begin
				cmd_valid = 1'b1;
				if (wa[31:29] != HDR_FLAG) begin
					cmd.op  = CMD_ERROR;
					cmd.err = ERR_HDR_FLAG;
					phase_d = PH_DROP;
				end else begin
					cmd.op      = CMD_HEADER;
					l1_low_d    = wb[26:24];
					hits_left_d = wb[23:16];
					phase_d     = (wb[23:16] != 8'd0) ? PH_HITS : PH_TRAIL1;
				end
			end
			PH_HITS: begin
				cmd_valid   = 1'b1;
				cmd.op      = CMD_HIT;
				hits_left_d = hits_left_q - 8'd1;
				if (hits_left_q == 8'd1) begin
					phase_d = PH_TRAIL1;
				end
			end
			PH_TRAIL1: begin
				cmd_valid = 1'b1;
				if (wa[31:29] != TRL_FLAG) begin
					cmd.op  = CMD_ERROR;
					cmd.err = ERR_TRL_FLAG;
					phase_d = PH_DROP;
				end else if (wb[26:24] != l1_low_q) begin
					cmd.op  = CMD_ERROR;
					cmd.err = ERR_L1_LOW;
					phase_d = PH_DROP;
				end else begin
					cmd.op  = CMD_TRAIL1;
					phase_d = PH_TRAIL2;
				end
			end
			PH_TRAIL2: begin
				cmd_valid = 1'b1;
				if (wa[31:28] != SEQ_FLAG1) begin
					cmd.op  = CMD_ERROR;
					cmd.err = ERR_SEQ_FLAG1;
					phase_d = PH_DROP;
				end else if (wb[31:28] != SEQ_FLAG2) begin
					cmd.op  = CMD_ERROR;
					cmd.err = ERR_SEQ_FLAG2;
					phase_d = PH_DROP;
				end else begin
					cmd.op  = CMD_SUMMARY;
					phase_d = PH_HEADER;
				end
			end
			default: begin
				// Drop phase and unused codes: beats are discarded.
			end
		endcase

		// Block end closes any packet; an unfinished one becomes a truncation error.
		if (item.block_last) begin
			if (phase_d == PH_HITS || phase_d == PH_TRAIL1 || phase_d == PH_TRAIL2) begin
				cmd_valid = 1'b1;
				cmd.op    = CMD_ERROR;
				cmd.err   = ERR_TRUNC;
			end
			phase_d     = PH_HEADER;
			hits_left_d = '0;
		end
	end

	assign cmd_push = accept && cmd_valid;

endmodule

/* rtl/rpd_cmd_queue.sv */
module rpd_cmd_queue
	import rpd_pkg::*;
#(
	parameter int DEPTH = CMD_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic q_full,
	input  logic rd_en,
	output cmd_t rd_cmd,
	output logic q_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          store_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign q_full  = (count_q == CW'(DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_cmd  = store_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* rtl/rpd_back.sv */
module rpd_back
	import rpd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  logic    cmd_empty,
	output logic    cmd_pop,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	logic        out_valid_q;
	result_t     res_q, res_d;
	logic        has_result;
	logic        out_free;
	logic [31:0] wa, wb;

	logic [2:0]  held_status_q;
	logic [31:0] held_l1_count_q;
	logic [7:0]  held_nhits_q;
	logic [15:0] held_timestamp_q;
	logic [23:0] held_frame_number_q;
	logic [4:0]  held_board_id_q;
	logic [2:0]  held_trailer_chip_q;
	logic [5:0]  held_channel_q;
	logic [17:0] held_last_count_q;

	assign wa = cmd.beat[31:0];
	assign wb = cmd.beat[63:32];

	assign has_result = (cmd.op == CMD_HIT) || (cmd.op == CMD_SUMMARY) || (cmd.op == CMD_ERROR);
	assign out_free   = !out_valid_q || pop;
	assign cmd_pop    = !cmd_empty && (!has_result || out_free);

	// Header and trailer fields held for the packet's later results.
	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.op == CMD_HEADER) begin
			held_status_q    <= wa[28:26];
			held_l1_count_q  <= {wa[25:0], wb[29:24]};
			held_nhits_q     <= wb[23:16];
			held_timestamp_q <= wb[15:0];
		end
		if (cmd_pop && cmd.op == CMD_TRAIL1) begin
			held_frame_number_q <= wa[28:5];
			held_board_id_q     <= wa[4:0];
			held_trailer_chip_q <= wb[29:27];
			held_channel_q      <= wb[23:18];
			held_last_count_q   <= wb[17:0];
		end
	end

	// Result assembly.
	always_comb begin
		res_d = '0;
		unique case (cmd.op)
			CMD_HIT: begin
				res_d.kind           = KIND_HIT;
				res_d.chip_id        = wa[29:27];
				res_d.code_bits      = wa[26:24];
				res_d.wide_value     = {wa[23:0], wb[29:0]};
				res_d.l1_count       = held_l1_count_q;
				res_d.time_stamp     = held_timestamp_q;
				res_d.hits_in_packet = held_nhits_q;
			end
			CMD_SUMMARY: begin
				res_d.kind            = KIND_SUMMARY;
				res_d.chip_id         = held_trailer_chip_q;
				res_d.code_bits       = held_status_q;
				res_d.wide_value      = {6'd0, wa[19:0], wb[27:0]};
				res_d.l1_count        = held_l1_count_q;
				res_d.time_stamp      = held_timestamp_q;
				res_d.hits_in_packet  = held_nhits_q;
				res_d.l1_frame_number = held_frame_number_q;
				res_d.board_id        = held_board_id_q;
				res_d.channel_id      = held_channel_q;
				res_d.last_count_word = held_last_count_q;
				res_d.seq_board_id    = wa[24:20];
			end
			CMD_ERROR: begin
				res_d.kind      = KIND_ERROR;
				res_d.code_bits = cmd.err;
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	// Output register: loads when free or being drained in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_pop && has_result) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && has_result) begin
			res_q <= res_d;
		end
	end

	assign empty  = !out_valid_q;
	assign result = res_q;

endmodule

/* rtl/readout_packet_deframer_core.sv */
// Splits a readout data block, given as 64-bit beats, into packets of one header beat, the
// announced number of hit beats and two trailer beats. Each hit beat yields a hit result at
// once; a good packet ends with one summary result, and a failed check or a block that ends
// inside a packet yields one numbered error, after which beats are dropped until block end.
// Header and first trailer beats yield no result. One beat is accepted every cycle as long as
// results are taken. The front parser is combinational, so a beat's command enters the
// command queue at its transfer edge; once it is at the queue head and the result register
// is free or drained, it moves into that register, which drives the result ports. The front
// part stalls only when the command queue (CMD_DEPTH entries) is full, and the back part
// stalls only when its result register is held.
module readout_packet_deframer_core
	import rpd_pkg::*;
#(
	parameter int CMD_DEPTH = CMD_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    push,
	output logic    full,
	output result_t result,
	output logic    empty,
	input  logic    pop
);

	logic cmd_push, cmd_full, cmd_pop, cmd_empty;
	cmd_t cmd_in, cmd_out;

	// Front part: parse and check beats.
	rpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.push     (push),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	// Queue between front and back.
	rpd_cmd_queue #(
		.DEPTH (CMD_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_cmd  (cmd_in),
		.q_full  (cmd_full),
		.rd_en   (cmd_pop),
		.rd_cmd  (cmd_out),
		.q_empty (cmd_empty)
	);

	// Back part: hold packet fields and build results.
	rpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

	assign full = cmd_full;

`ifndef SYNTHESIS
	// The front part never issues a command into a full queue.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command issued into full queue");

	// An error result carries nothing but its code.
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == KIND_ERROR) |->
			(result.wide_value == '0 && result.l1_count == '0 && result.chip_id == '0))
		else $error("error result carries packet fields");

	// A waiting result has a defined kind.
	a_kind_known: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.kind == KIND_HIT || result.kind == KIND_SUMMARY ||
			result.kind == KIND_ERROR))
		else $error("result with undefined kind");
`endif

endmodule

/* bench/readout_packet_deframer_core_tb.sv */
module readout_packet_deframer_core_tb;
	import rpd_pkg::*;

	localparam int CLK_PERIOD = 4;
	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_ITEMS = 800;
	localparam int CALM_ITEMS = 150;
	localparam int DRAIN_CYCLES = 10;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam int SHOWN_MISMATCHES = 10;

	// How a generated packet is broken, if at all.
	typedef enum int {
		FAULT_NONE,
		FAULT_HDR_FLAG,
		FAULT_TRL_FLAG,
		FAULT_L1_LOW,
		FAULT_SEQ_FLAG1,
		FAULT_SEQ_FLAG2,
		FAULT_TRUNC
	} fault_t;

	// Content of the packet fields: random, or one of the two extremes.
	typedef enum int {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES
	} fill_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	item_t   item = '0;
	logic    push = 1'b0;
	logic    full;
	result_t result;
	logic    empty;
	logic    pop = 1'b0;

	item_t   pending_items[$];
	result_t expected_results[$];
	bit      in_flight = 1'b0;
	int      send_idle = 0;
	int      take_idle = 0;
	int      error_count = 0;

	// Deframer state as the beats are taken in.
	phase_t      fr_phase = PH_HEADER;
	logic [7:0]  hits_left = '0;
	logic [2:0]  hd_status = '0;
	logic [31:0] hd_l1 = '0;
	logic [7:0]  hd_hits = '0;
	logic [15:0] hd_ts = '0;
	logic [23:0] tl_frame = '0;
	logic [4:0]  tl_board = '0;
	logic [2:0]  tl_chip = '0;
	logic [5:0]  tl_channel = '0;
	logic [17:0] tl_last_count = '0;

	readout_packet_deframer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.push(push),
		.full(full),
		.result(result),
		.empty(empty),
		.pop(pop)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic result_t error_result(logic [2:0] code);
		result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.code_bits = code;
		return r;
	endfunction

	// Works out the result, if any, that one beat causes and queues it.
	task automatic deframe_beat(input item_t it);
		logic [31:0] wa;
		logic [31:0] wb;
		result_t r;
		bit has_result;
		wa = it.beat[31:0];
		wb = it.beat[63:32];
		r = '0;
		has_result = 1'b0;
		case (fr_phase)
		PH_HEADER: begin
			if (wa[31:29] != HDR_FLAG) begin
				r = error_result(ERR_HDR_FLAG);
				has_result = 1'b1;
				fr_phase = PH_DROP;
			end else begin
				hd_status = wa[28:26];
				hd_l1 = {wa[25:0], wb[29:24]};
				hd_hits = wb[23:16];
				hd_ts = wb[15:0];
				hits_left = wb[23:16];
				if (hits_left != 0) begin
					fr_phase = PH_HITS;
				end else begin
					fr_phase = PH_TRAIL1;
				end
			end
		end
		PH_HITS: begin
			r.kind = KIND_HIT;
			r.chip_id = wa[29:27];
			r.code_bits = wa[26:24];
			r.wide_value = {wa[23:0], wb[29:0]};
			r.l1_count = hd_l1;
			r.time_stamp = hd_ts;
			r.hits_in_packet = hd_hits;
			has_result = 1'b1;
			hits_left = hits_left - 8'd1;
			if (hits_left == 0) begin
				fr_phase = PH_TRAIL1;
			end
		end
		PH_TRAIL1: begin
			if (wa[31:29] != TRL_FLAG) begin
				r = error_result(ERR_TRL_FLAG);
				has_result = 1'b1;
				fr_phase = PH_DROP;
			end else begin
				tl_frame = wa[28:5];
				tl_board = wa[4:0];
				tl_chip = wb[29:27];
				tl_channel = wb[23:18];
				tl_last_count = wb[17:0];
				if (wb[26:24] != hd_l1[2:0]) begin
					r = error_result(ERR_L1_LOW);
					has_result = 1'b1;
					fr_phase = PH_DROP;
				end else begin
					fr_phase = PH_TRAIL2;
				end
			end
		end
		PH_TRAIL2: begin
			if (wa[31:28] != SEQ_FLAG1) begin
				r = error_result(ERR_SEQ_FLAG1);
				has_result = 1'b1;
				fr_phase = PH_DROP;
			end else if (wb[31:28] != SEQ_FLAG2) begin
				r = error_result(ERR_SEQ_FLAG2);
				has_result = 1'b1;
				fr_phase = PH_DROP;
			end else begin
				r.kind = KIND_SUMMARY;
				r.chip_id = tl_chip;
				r.code_bits = hd_status;
				r.wide_value = {6'd0, wa[19:0], wb[27:0]};
				r.l1_count = hd_l1;
				r.time_stamp = hd_ts;
				r.hits_in_packet = hd_hits;
				r.l1_frame_number = tl_frame;
				r.board_id = tl_board;
				r.channel_id = tl_channel;
				r.last_count_word = tl_last_count;
				r.seq_board_id = wa[24:20];
				has_result = 1'b1;
				fr_phase = PH_HEADER;
			end
		end
		default: begin
			// Beats are dropped until the block ends.
		end
		endcase

		// The block end closes any open packet with a truncation error.
		if (it.block_last) begin
			if (fr_phase == PH_HITS || fr_phase == PH_TRAIL1 || fr_phase == PH_TRAIL2) begin
				r = error_result(ERR_TRUNC);
				has_result = 1'b1;
			end
			fr_phase = PH_HEADER;
			hits_left = '0;
		end
		if (has_result) begin
			expected_results.push_back(r);
		end
	endtask

	function automatic string show_result(result_t r);
		return $sformatf({"kind=%0d chip=%0d code=%0d wide=%h l1=%h ts=%h hits=%0d ",
			"frame=%h board=%0d chan=%0d last=%h seqb=%0d"},
			r.kind, r.chip_id, r.code_bits, r.wide_value, r.l1_count, r.time_stamp,
			r.hits_in_packet, r.l1_frame_number, r.board_id, r.channel_id,
			r.last_count_word, r.seq_board_id);
	endfunction

	task automatic report_failure(input string what, input result_t want, input result_t got);
		error_count++;
		if (error_count <= SHOWN_MISMATCHES) begin
			$display("%0t: %s", $time, what);
			$display("  expected %s", show_result(want));
			$display("  actual   %s", show_result(got));
		end
	endtask

	// Result check first, then prediction of the beat taken at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					report_failure("result transfer with nothing expected", '0, result);
				end else begin
					if (result.kind !== expected_results[0].kind ||
						result.chip_id !== expected_results[0].chip_id ||
						result.code_bits !== expected_results[0].code_bits ||
						result.wide_value !== expected_results[0].wide_value ||
						result.l1_count !== expected_results[0].l1_count ||
						result.time_stamp !== expected_results[0].time_stamp ||
						result.hits_in_packet !== expected_results[0].hits_in_packet ||
						result.l1_frame_number !== expected_results[0].l1_frame_number ||
						result.board_id !== expected_results[0].board_id ||
						result.channel_id !== expected_results[0].channel_id ||
						result.last_count_word !== expected_results[0].last_count_word ||
						result.seq_board_id !== expected_results[0].seq_board_id) begin
						report_failure("result mismatch", expected_results[0], result);
					end
					void'(expected_results.pop_front());
				end
			end
			if (push && !full) begin
				deframe_beat(item);
				void'(pending_items.pop_front());
				in_flight = 1'b0;
			end
		end
	end

	// Beat and pop driver, with random idle bursts until the final stretch.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_flight) begin
				if (send_idle > 0) begin
					send_idle--;
					push <= 1'b0;
				end else if (pending_items.size() > CALM_ITEMS && $urandom_range(0, 5) == 0) begin
					send_idle = $urandom_range(0, 7);
					push <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item <= pending_items[0];
					push <= 1'b1;
					in_flight = 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
			if (take_idle > 0) begin
				take_idle--;
				pop <= 1'b0;
			end else if (pending_items.size() > CALM_ITEMS && $urandom_range(0, 4) == 0) begin
				take_idle = $urandom_range(0, 7);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	function automatic logic [63:0] draw_bits(fill_t fill);
		case (fill)
		FILL_ZERO: return '0;
		FILL_ONES: return '1;
		default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [2:0] other3(logic [2:0] good);
		logic [2:0] step;
		step = 3'($urandom_range(1, 7));
		return good + step;
	endfunction

	function automatic logic [3:0] other4(logic [3:0] good);
		logic [3:0] step;
		step = 4'($urandom_range(1, 15));
		return good + step;
	endfunction

	task automatic add_beat(input logic [63:0] beat, input bit block_last);
		item_t it;
		it.beat = beat;
		it.block_last = block_last;
		pending_items.push_back(it);
	endtask

	// Random beats up to the block end, unless the block is already closed.
	task automatic drop_tail(input bit closed);
		int n;
		if (!closed) begin
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++) begin
				add_beat({$urandom, $urandom}, i == n - 1);
			end
		end
	endtask

	// Queues one packet; a broken or truncated packet always closes its block.
	task automatic queue_packet(input int n_hits, input fault_t fault, input fill_t fill,
		input int cut, input bit close_block);
		logic [63:0] bits;
		logic [31:0] wa;
		logic [31:0] wb;
		logic [31:0] l1;
		logic [7:0]  announced;
		logic [2:0]  l1_low;
		bit fail_last;
		bit broken;
		bit trunc;
		fail_last = ($urandom_range(0, 2) == 0);
		trunc = (fault == FAULT_TRUNC);
		announced = n_hits[7:0];

		// Header beat.
		bits = draw_bits(fill);
		l1 = bits[31:0];
		wa = {HDR_FLAG, bits[34:32], l1[31:6]};
		wb = {bits[52:51], l1[5:0], announced, bits[50:35]};
		broken = (fault == FAULT_HDR_FLAG);
		if (broken) begin
			wa[31:29] = other3(HDR_FLAG);
		end
		add_beat({wb, wa}, (trunc && cut == 0) || (broken && fail_last));
		if (broken) begin
			drop_tail(fail_last);
			return;
		end
		if (trunc && cut == 0) begin
			return;
		end

		// Hit beats.
		for (int i = 1; i <= n_hits; i++) begin
			bits = draw_bits(fill);
			wa = {bits[61:60], bits[56:54], bits[59:57], bits[53:30]};
			wb = {bits[63:62], bits[29:0]};
			add_beat({wb, wa}, trunc && cut == i);
			if (trunc && cut == i) begin
				return;
			end
		end

		// First trailer beat.
		bits = draw_bits(fill);
		l1_low = l1[2:0];
		if (fault == FAULT_L1_LOW) begin
			l1_low = other3(l1[2:0]);
		end
		wa = {TRL_FLAG, bits[23:0], bits[28:24]};
		if (fault == FAULT_TRL_FLAG) begin
			wa[31:29] = other3(TRL_FLAG);
		end
		wb = {bits[57:56], bits[31:29], l1_low, bits[37:32], bits[55:38]};
		broken = (fault == FAULT_TRL_FLAG || fault == FAULT_L1_LOW);
		add_beat({wb, wa}, (trunc && cut == n_hits + 1) || (broken && fail_last));
		if (broken) begin
			drop_tail(fail_last);
			return;
		end
		if (trunc) begin
			return;
		end

		// Second trailer beat with the sequence count.
		bits = draw_bits(fill);
		wa = {SEQ_FLAG1, bits[55:53], bits[52:48], bits[47:28]};
		wb = {SEQ_FLAG2, bits[27:0]};
		if (fault == FAULT_SEQ_FLAG1) begin
			wa[31:28] = other4(SEQ_FLAG1);
		end
		if (fault == FAULT_SEQ_FLAG2) begin
			wb[31:28] = other4(SEQ_FLAG2);
		end
		broken = (fault == FAULT_SEQ_FLAG1 || fault == FAULT_SEQ_FLAG2);
		add_beat({wb, wa}, broken ? fail_last : close_block);
		if (broken) begin
			drop_tail(fail_last);
		end
	endtask

	// Stimulus, reset and end of run.
	initial begin
		int n_packets;
		int n_hits;
		int pick;
		fault_t fault;

		// Directed packets: field extremes, every check, truncation.
		queue_packet(0, FAULT_NONE, FILL_ZERO, 0, 1'b1);
		queue_packet(1, FAULT_NONE, FILL_ONES, 0, 1'b1);
		queue_packet(0, FAULT_HDR_FLAG, FILL_RANDOM, 0, 1'b1);
		queue_packet(0, FAULT_TRL_FLAG, FILL_RANDOM, 0, 1'b1);
		queue_packet(0, FAULT_L1_LOW, FILL_RANDOM, 0, 1'b1);
		queue_packet(0, FAULT_SEQ_FLAG1, FILL_RANDOM, 0, 1'b1);
		queue_packet(0, FAULT_SEQ_FLAG2, FILL_RANDOM, 0, 1'b1);
		queue_packet(255, FAULT_TRUNC, FILL_RANDOM, 1, 1'b1);
		queue_packet(1, FAULT_TRUNC, FILL_RANDOM, 0, 1'b1);

		// Random blocks of mostly good packets, with noise and broken packets mixed in.
		while (pending_items.size() < RANDOM_ITEMS) begin
			if ($urandom_range(0, 19) == 0) begin
				drop_tail(1'b0);
			end else begin
				n_packets = $urandom_range(1, 4);
				for (int p = 0; p < n_packets; p++) begin
					pick = $urandom_range(0, 19);
					if (pick < 14) begin
						fault = FAULT_NONE;
					end else begin
						fault = fault_t'(pick - 13);
					end
					pick = $urandom_range(0, 99);
					if (pick < 2) begin
						n_hits = $urandom_range(128, 255);
					end else if (pick < 10) begin
						n_hits = $urandom_range(5, 20);
					end else begin
						n_hits = $urandom_range(0, 4);
					end
					queue_packet(n_hits, fault, FILL_RANDOM, $urandom_range(0, n_hits + 1),
						p == n_packets - 1);
					if (fault != FAULT_NONE) begin
						break;
					end
				end
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog for a hung run.
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

/* readout_packet_deframer_core.f */
rtl/rpd_pkg.sv
rtl/rpd_front.sv
rtl/rpd_cmd_queue.sv
rtl/rpd_back.sv
rtl/readout_packet_deframer_core.sv
bench/readout_packet_deframer_core_tb.sv
